// ----- rtl/amu_pkg.sv -----
// Shared types, widths and constants for the ADSR-modulated energy update block.
// Holds the word structs, register indexes, region codes and the sine table.
// No dependencies; every rtl file imports it.
package amu_pkg;

  localparam int TIME_W     = 32;
  localparam int ENERGY_W   = 32;
  localparam int REGION_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LEVEL_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int SUM_W      = ENERGY_W + 1;
  localparam int BOUND_W    = TIME_W + 3;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(32768);

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_FREQ    = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = CFG_IDX_W'(6);

  localparam logic [REGION_W-1:0] REGION_ATTACK  = REGION_W'(0);
  localparam logic [REGION_W-1:0] REGION_DECAY   = REGION_W'(1);
  localparam logic [REGION_W-1:0] REGION_SUSTAIN = REGION_W'(2);
  localparam logic [REGION_W-1:0] REGION_RELEASE = REGION_W'(3);

  // bit-serial divider: quotient never exceeds one in Q1.15
  localparam int DIV_DEN_W = TIME_W;
  localparam int DIV_Q_W   = GAIN_W;
  localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

  // sine table
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_MAG_W      = 15;
  localparam int SINE_U_W        = SINE_TABLE_BITS - 1;
  localparam int SINE_ROM_W      = SINE_TABLE_BITS - 2;
  localparam int unsigned QUARTER_N = 2 ** (SINE_TABLE_BITS - 2);
  localparam logic [SINE_U_W-1:0] QUARTER_IDX = SINE_U_W'(QUARTER_N);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

  // serial multiplier: (|sum| * gain) by |sine|
  localparam int MUL_A_W   = SUM_W + GAIN_W - 1;
  localparam int MUL_B_W   = SINE_MAG_W;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);
  localparam int ROUND_SHIFT = 30;
  localparam logic [MUL_P_W-1:0] ROUND_HALF = MUL_P_W'(1) << (ROUND_SHIFT - 1);

  typedef struct packed {
    logic [TIME_W-1:0]          current_time;
    logic signed [ENERGY_W-1:0] energy_in;
  } in_word_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy_out;
    logic [REGION_W-1:0]        region;
  } out_word_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] product;
  } mul_rsp_t;

  typedef logic [SINE_MAG_W-1:0] sine_rom_t [QUARTER_N];

  // Q1.15 sine of u quarter steps; 11th-order Taylor series in Q30
  function automatic logic [SINE_MAG_W-1:0] sine_quarter_entry(input int unsigned u);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] e;
    longint      acc;
    x    = (64'(u) * HALF_PI_Q30) / QUARTER_N;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - longint'(term);
    if (acc < 0) acc = 0;
    s = 64'(acc);
    if (s > Q30_ONE) s = Q30_ONE;
    e = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    if (e > 64'd32767) e = 64'd32767;
    return e[SINE_MAG_W-1:0];
  endfunction

  function automatic sine_rom_t sine_rom_build();
    sine_rom_t rom;
    for (int i = 0; i < QUARTER_N; i++) begin
      rom[i] = sine_quarter_entry(i);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_rom_build();
  localparam logic [SINE_MAG_W-1:0] SINE_PEAK = sine_quarter_entry(QUARTER_N);

endpackage

// ----- rtl/adsr_modulated_energy_update_top.sv -----
// Top level of the ADSR-modulated energy update: config registers, sequencer,
// envelope region select and final rounding. Depends on amu_pkg, amu_div,
// amu_mul and amu_sine.
//
//   channel  signals                              direction
//   in       in_valid, in_ready, in_data          word in: current_time, energy_in
//   out      out_valid, out_ready, out_data       word out: energy_out, region
//   cfg      cfg_valid, cfg_ready, cfg_index,     register write, always ready
//            cfg_data
//
// One word at a time: a new word is taken only in the idle state, after the last
// one has gone through the bit-serial divider (16 steps) and the bit-serial
// multiplier (15 steps).
// Synchronous reset clears the sequencer, state and registers to their defaults.
// A result waits in the output register while the next word is taken; a word
// finishes only once that register is free.
module adsr_modulated_energy_update_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  amu_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output amu_pkg::out_word_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [amu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [amu_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import amu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOUND,
    ST_SELECT,
    ST_NUMER,
    ST_DIVIDE,
    ST_PROD,
    ST_MULT,
    ST_FINISH
  } state_t;

  state_t state;

  // config registers
  logic [TIME_W-1:0]  attack_ticks;
  logic [TIME_W-1:0]  decay_ticks;
  logic [TIME_W-1:0]  sustain_ticks;
  logic [TIME_W-1:0]  release_ticks;
  logic [LEVEL_W-1:0] sustain_level;
  logic [TIME_W-1:0]  frequency_step;
  logic [TIME_W-1:0]  phase_offset;

  // item state
  logic [TIME_W-1:0]          last_time;
  logic signed [ENERGY_W-1:0] stored_energy;

  // datapath
  logic [TIME_W-1:0]  cur_time;
  logic [TIME_W-1:0]  delta;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_mag;
  logic               sum_neg;
  logic [BOUND_W-1:0] b2;
  logic [BOUND_W-1:0] b3;
  logic [BOUND_W-1:0] b4;
  logic [TIME_W-1:0]  phase_mul;
  logic [TIME_W-1:0]  phase;
  logic [REGION_W-1:0] region;
  logic [TIME_W-1:0]  sel_x;
  logic [GAIN_W-1:0]  sel_m;
  logic [TIME_W-1:0]  sel_den;
  logic [GAIN_W-1:0]  sel_base;
  logic [GAIN_W-1:0]  gain;

  // region select, combinational
  logic [LEVEL_W-1:0]  lvl;
  logic [BOUND_W-1:0]  delta_x;
  logic [REGION_W-1:0] region_next;
  logic [TIME_W-1:0]   x_next;
  logic [GAIN_W-1:0]   m_next;
  logic [TIME_W-1:0]   den_next;
  logic [GAIN_W-1:0]   base_next;

  // finish
  logic [MUL_P_W-1:0]  rnd_sum;
  logic [SUM_W-1:0]    rounded;
  logic [SUM_W-1:0]    mag_sat;
  logic                sine_neg_eff;
  logic                res_neg;
  logic [ENERGY_W-1:0] result;

  logic [SINE_MAG_W-1:0] sine_mag;
  logic                  sine_neg;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ticks   <= TIME_W'(1);
      decay_ticks    <= TIME_W'(1);
      sustain_ticks  <= '0;
      release_ticks  <= TIME_W'(1);
      sustain_level  <= LEVEL_W'(16384);
      frequency_step <= '0;
      phase_offset   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ATTACK:  attack_ticks   <= cfg_data;
        REG_DECAY:   decay_ticks    <= cfg_data;
        REG_SUSTAIN: sustain_ticks  <= cfg_data;
        REG_RELEASE: release_ticks  <= cfg_data;
        REG_LEVEL:   sustain_level  <= cfg_data[LEVEL_W-1:0];
        REG_FREQ:    frequency_step <= cfg_data;
        REG_OFFSET:  phase_offset   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    lvl     = (sustain_level > GAIN_ONE) ? GAIN_ONE : sustain_level;
    delta_x = BOUND_W'(delta);
    if (delta_x < BOUND_W'(attack_ticks)) begin
      region_next = REGION_ATTACK;
      x_next      = delta;
      m_next      = GAIN_ONE;
      den_next    = attack_ticks;
      base_next   = '0;
    end else if (delta_x < b2) begin
      // d - (delta - a)
      region_next = REGION_DECAY;
      x_next      = TIME_W'(b2 - delta_x);
      m_next      = GAIN_ONE - lvl;
      den_next    = decay_ticks;
      base_next   = lvl;
    end else if (delta_x < b3) begin
      region_next = REGION_SUSTAIN;
      x_next      = '0;
      m_next      = '0;
      den_next    = TIME_W'(1);
      base_next   = lvl;
    end else begin
      // r - (delta - b3); past the ramp end the gain is zero
      region_next = REGION_RELEASE;
      base_next   = '0;
      if (delta_x < b4) begin
        x_next   = TIME_W'(b4 - delta_x);
        m_next   = GAIN_ONE;
        den_next = release_ticks;
      end else begin
        x_next   = '0;
        m_next   = '0;
        den_next = TIME_W'(1);
      end
    end
  end

  always_comb begin
    div_req.start = (state == ST_NUMER);
    div_req.num   = DIV_NUM_W'(sel_x) * DIV_NUM_W'(sel_m);
    div_req.den   = sel_den;
    mul_req.start = (state == ST_PROD);
    mul_req.a     = MUL_A_W'(sum_mag) * MUL_A_W'(gain);
    mul_req.b     = sine_mag;
  end

  always_comb begin
    rnd_sum      = mul_rsp.product + ROUND_HALF;
    rounded      = rnd_sum[MUL_P_W-1 -: SUM_W];
    sine_neg_eff = sine_neg && (sine_mag != '0);
    res_neg      = sum_neg ^ sine_neg_eff;
    if (res_neg) begin
      mag_sat = (rounded > SUM_W'(33'h0_8000_0000)) ? SUM_W'(33'h0_8000_0000) : rounded;
      result  = ~mag_sat[ENERGY_W-1:0] + 1'b1;
    end else begin
      mag_sat = (rounded > SUM_W'(33'h0_7FFF_FFFF)) ? SUM_W'(33'h0_7FFF_FFFF) : rounded;
      result  = mag_sat[ENERGY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      last_time     <= '0;
      stored_energy <= '0;
    end else begin
      // in ST_FINISH the output register is handled by the state below
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur_time  <= in_data.current_time;
            last_time <= in_data.current_time;
            delta     <= in_data.current_time - last_time;
            sum       <= {stored_energy[ENERGY_W-1], stored_energy}
                       + {in_data.energy_in[ENERGY_W-1], in_data.energy_in};
            state     <= ST_BOUND;
          end
        end
        ST_BOUND: begin
          b2 <= BOUND_W'(attack_ticks) + BOUND_W'(decay_ticks);
          b3 <= BOUND_W'(attack_ticks) + BOUND_W'(decay_ticks) + BOUND_W'(sustain_ticks);
          b4 <= BOUND_W'(attack_ticks) + BOUND_W'(decay_ticks) + BOUND_W'(sustain_ticks)
              + BOUND_W'(release_ticks);
          phase_mul <= frequency_step * cur_time;
          sum_neg   <= sum[SUM_W-1];
          sum_mag   <= sum[SUM_W-1] ? (~sum + 1'b1) : sum;
          state     <= ST_SELECT;
        end
        ST_SELECT: begin
          region   <= region_next;
          sel_x    <= x_next;
          sel_m    <= m_next;
          sel_den  <= den_next;
          sel_base <= base_next;
          phase    <= phase_mul + phase_offset;
          state    <= ST_NUMER;
        end
        ST_NUMER: begin
          state <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_rsp.done) begin
            gain  <= sel_base + div_rsp.quo;
            state <= ST_PROD;
          end
        end
        ST_PROD: begin
          state <= ST_MULT;
        end
        ST_MULT: begin
          if (mul_rsp.done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.energy_out <= result;
            out_data.region     <= region;
            stored_energy       <= result;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  amu_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  amu_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  amu_sine u_sine (
    .clk   (clk),
    .phase (phase),
    .mag   (sine_mag),
    .neg   (sine_neg)
  );

endmodule

// ----- rtl/amu_div.sv -----
// Restoring divider, one quotient bit per cycle, for the envelope ramp gain.
// Depends on amu_pkg. Quotient must fit DIV_Q_W bits (num >> DIV_Q_W < den).
module amu_div (
  input  logic             clk,
  input  logic             rst,
  input  amu_pkg::div_req_t req,
  output amu_pkg::div_rsp_t rsp
);
  import amu_pkg::*;

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_Q_W-1:0]   qsh;   // low numerator bits shift out, quotient bits shift in
  logic [DIV_CNT_W-1:0] cnt;
  logic                 done;
  logic [DIV_DEN_W+1:0] trial;

  assign trial = {1'b0, rem, qsh[DIV_Q_W-1]} - {2'b00, den};
  assign rsp.done = done;
  assign rsp.quo  = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem <= req.num[DIV_NUM_W-1 -: DIV_DEN_W];
        qsh <= req.num[DIV_Q_W-1:0];
        den <= req.den;
        cnt <= DIV_CNT_W'(DIV_Q_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == DIV_CNT_W'(1));
        if (!trial[DIV_DEN_W+1]) begin
          rem <= trial[DIV_DEN_W-1:0];
          qsh <= {qsh[DIV_Q_W-2:0], 1'b1};
        end else begin
          rem <= {rem[DIV_DEN_W-2:0], qsh[DIV_Q_W-1]};
          qsh <= {qsh[DIV_Q_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

// ----- rtl/amu_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on amu_pkg. Product is {hi, lo} once done pulses.
module amu_mul (
  input  logic             clk,
  input  logic             rst,
  input  amu_pkg::mul_req_t req,
  output amu_pkg::mul_rsp_t rsp
);
  import amu_pkg::*;

  logic [MUL_A_W-1:0]   mcand;
  logic [MUL_A_W-1:0]   hi;
  logic [MUL_B_W-1:0]   lo;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 done;
  logic [MUL_A_W:0]     psum;

  assign psum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign rsp.done    = done;
  assign rsp.product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        mcand <= req.a;
        hi    <= '0;
        lo    <= req.b;
        cnt   <= MUL_CNT_W'(MUL_B_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == MUL_CNT_W'(1));
        hi   <= psum[MUL_A_W:1];
        lo   <= {psum[0], lo[MUL_B_W-1:1]};
      end
    end
  end

endmodule

// ----- rtl/amu_sine.sv -----
// Sine lookup: folds the top phase bits onto a quarter-wave table.
// Depends on amu_pkg (SINE_ROM, SINE_PEAK). The output is registered.
module amu_sine (
  input  logic                            clk,
  input  logic [amu_pkg::TIME_W-1:0]      phase,
  output logic [amu_pkg::SINE_MAG_W-1:0]  mag,
  output logic                            neg
);
  import amu_pkg::*;

  logic [SINE_TABLE_BITS-1:0] k;
  logic [SINE_U_W-1:0]        m;
  logic [SINE_U_W-1:0]        u;

  assign k = phase[TIME_W-1 -: SINE_TABLE_BITS];
  assign m = k[SINE_U_W-1:0];
  // second quarter mirrors: half - m, taken mod 2^SINE_U_W
  assign u = (m <= QUARTER_IDX) ? m : (~m + 1'b1);

  always_ff @(posedge clk) begin
    mag <= u[SINE_U_W-1] ? SINE_PEAK : SINE_ROM[u[SINE_ROM_W-1:0]];
    neg <= k[SINE_TABLE_BITS-1];
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for adsr_modulated_energy_update_top: a directed word table,
// then random words over many register settings, checked by a local envelope model
// or fixed row values. Depends on amu_pkg and rtl top; needs no files or arguments.
module tb;
  import amu_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2000000;
  localparam int unsigned SETTING_COUNT = 13;
  localparam int unsigned WORDS_PER_SETTING = 150;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned IDLE_PCT = 18;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(7);
  localparam int TBL_BITS = 10;
  localparam int unsigned QUARTER = 1 << (TBL_BITS - 2);
  localparam int unsigned HALF = 1 << (TBL_BITS - 1);
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] GAIN_FULL = 64'd32768;

  typedef struct {
    logic [31:0] atk;
    logic [31:0] dcy;
    logic [31:0] sus;
    logic [31:0] rel;
    logic [31:0] level;
    logic [31:0] freq;
    logic [31:0] offset;
  } env_cfg_t;

  typedef struct {
    int        sel;
    in_word_t  w;
    bit        fixed;
    out_word_t want;
  } dir_row_t;

  typedef struct {
    bit        fixed;
    out_word_t want;
  } typed_want_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  adsr_modulated_energy_update_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // envelope model state
  env_cfg_t model_cfg;
  logic [31:0] held_time = '0;
  logic signed [63:0] held_energy = '0;
  logic [14:0] quarter_sine [0:QUARTER];

  out_word_t energy_q[$];
  typed_want_t typed_q[$];
  dir_row_t dir_rows[$];
  env_cfg_t dir_cfg [0:4];

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned sent_cnt = 0;
  int unsigned settings_loaded = 0;
  int unsigned saturated = 0;
  int unsigned region_hits [4] = '{0, 0, 0, 0};
  int unsigned stall_left = 0;
  int unsigned hold_pct = IDLE_PCT;
  logic calm = 1'b0;
  logic [31:0] sent_time = '0;

  // Q1.15 magnitude of sine at u quarter steps, Taylor series in Q30
  function automatic logic [14:0] taylor_sine(int unsigned u);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] e;
    longint acc;
    x = (64'(u) * 64'd1686629713) / 64'(QUARTER);
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 5; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    s = 64'(acc);
    if (s > ONE_Q30) s = ONE_Q30;
    e = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (e > 64'd32767) e = 64'd32767;
    return e[14:0];
  endfunction

  function automatic out_word_t energy_update(in_word_t w);
    logic [31:0] dt;
    logic [63:0] delta;
    logic [63:0] a;
    logic [63:0] d;
    logic [63:0] su;
    logic [63:0] r;
    logic [63:0] lvl;
    logic [63:0] b3;
    logic [63:0] gain;
    logic [63:0] tt;
    logic [63:0] mag_e;
    logic [63:0] mag_s;
    logic [63:0] prod;
    logic [63:0] rnd;
    logic [31:0] phase;
    logic [31:0] mag32;
    logic [TBL_BITS-1:0] k;
    logic [TBL_BITS-2:0] m;
    int unsigned u;
    logic signed [63:0] sum;
    logic sine_neg;
    out_word_t o;
    dt = w.current_time - held_time;
    delta = 64'(dt);
    a = 64'(model_cfg.atk);
    d = 64'(model_cfg.dcy);
    su = 64'(model_cfg.sus);
    r = 64'(model_cfg.rel);
    lvl = (model_cfg.level > 32'd32768) ? GAIN_FULL : 64'(model_cfg.level);
    b3 = a + d + su;
    if (delta < a) begin
      o.region = REGION_ATTACK;
      gain = (delta * GAIN_FULL) / a;
    end else if (delta < a + d) begin
      o.region = REGION_DECAY;
      tt = delta - a;
      gain = lvl + ((GAIN_FULL - lvl) * (d - tt)) / d;
    end else if (delta < b3) begin
      o.region = REGION_SUSTAIN;
      gain = lvl;
    end else begin
      o.region = REGION_RELEASE;
      tt = delta - b3;
      gain = (tt < r) ? ((r - tt) * GAIN_FULL) / r : 64'd0;
    end
    phase = model_cfg.freq * w.current_time + model_cfg.offset;
    k = phase[31 -: TBL_BITS];
    m = k[TBL_BITS-2:0];
    u = (m <= QUARTER) ? m : HALF - m;
    mag_s = 64'(quarter_sine[u]);
    sine_neg = k[TBL_BITS-1] && (mag_s != 0);
    sum = held_energy + w.energy_in;
    mag_e = (sum < 0) ? -sum : sum;
    prod = mag_e * gain * mag_s;
    rnd = (prod + (ONE_Q30 >> 1)) >> 30;
    if ((sum < 0) != sine_neg) begin
      if (rnd > 64'h8000_0000) rnd = 64'h8000_0000;
      mag32 = rnd[31:0];
      o.energy_out = -mag32;
    end else begin
      if (rnd > 64'h7FFF_FFFF) rnd = 64'h7FFF_FFFF;
      o.energy_out = rnd[31:0];
    end
    held_time = w.current_time;
    held_energy = o.energy_out;
    return o;
  endfunction

  function automatic env_cfg_t make_cfg(logic [31:0] a, logic [31:0] d, logic [31:0] s,
                                        logic [31:0] r, logic [31:0] l, logic [31:0] f,
                                        logic [31:0] o);
    env_cfg_t c;
    c.atk = a;
    c.dcy = d;
    c.sus = s;
    c.rel = r;
    c.level = l;
    c.freq = f;
    c.offset = o;
    return c;
  endfunction

  function automatic logic [31:0] ramp_len();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic env_cfg_t random_settings();
    env_cfg_t c;
    c.atk = ramp_len();
    c.dcy = ramp_len();
    c.sus = ramp_len();
    c.rel = ramp_len();
    case ($urandom_range(3))
      0: c.level = $urandom_range(0, 32768);
      1: c.level = 32'd32768;
      2: c.level = $urandom_range(32769, 65535);
      default: c.level = 32'd0;
    endcase
    // upper bits of the level word are don't-care
    if ($urandom_range(1)) c.level[31:16] = 16'($urandom);
    case ($urandom_range(5))
      0: c.freq = 32'd0;
      1: c.freq = $urandom_range(1, 1 << 20);
      default: c.freq = $urandom;
    endcase
    c.offset = $urandom;
    return c;
  endfunction

  // picks a timestamp so the tick distance lands in every region and on its borders
  function automatic logic [31:0] next_time(env_cfg_t c);
    logic [63:0] bnd;
    logic [63:0] span;
    logic [31:0] delta;
    case ($urandom_range(9))
      0, 1: delta = $urandom;
      2, 3: begin
        case ($urandom_range(3))
          0: bnd = 64'(c.atk);
          1: bnd = 64'(c.atk) + 64'(c.dcy);
          2: bnd = 64'(c.atk) + 64'(c.dcy) + 64'(c.sus);
          default: bnd = 64'(c.atk) + 64'(c.dcy) + 64'(c.sus) + 64'(c.rel);
        endcase
        delta = bnd[31:0] + 32'($urandom_range(0, 2)) - 32'd1;
      end
      default: begin
        span = 64'(c.atk) + 64'(c.dcy) + 64'(c.sus) + 64'(c.rel) + 64'd8;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        delta = $urandom_range(0, span[31:0]);
      end
    endcase
    return sent_time + delta;
  endfunction

  function automatic logic [31:0] next_energy();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(int sel, logic [31:0] t, logic [31:0] e, bit fixed,
                         logic [31:0] want_e, logic [REGION_W-1:0] want_r);
    dir_row_t row;
    row.sel = sel;
    row.w.current_time = t;
    row.w.energy_in = e;
    row.fixed = fixed;
    row.want.energy_out = want_e;
    row.want.region = want_r;
    dir_rows.push_back(row);
  endtask

  // leaves valid high on return; the caller or the next word decides when it drops
  task automatic send_word(in_word_t w, bit fixed, out_word_t want);
    typed_want_t tw;
    tw.fixed = fixed;
    tw.want = want;
    typed_q.push_back(tw);
    if (hold_pct != 0 && $urandom_range(99) < hold_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
    sent_time = w.current_time;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(env_cfg_t c);
    write_reg(REG_ATTACK, c.atk);
    write_reg(REG_DECAY, c.dcy);
    write_reg(REG_SUSTAIN, c.sus);
    write_reg(REG_RELEASE, c.rel);
    write_reg(REG_LEVEL, c.level);
    write_reg(REG_FREQ, c.freq);
    write_reg(REG_OFFSET, c.offset);
    write_reg(REG_NONE, $urandom);
    cfg_valid <= 1'b0;
    settings_loaded++;
    @(posedge clk);
  endtask

  // hold the sender until every word in flight has produced its result
  task automatic settle();
    in_valid <= 1'b0;
    while (results_seen < sent_cnt) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(99) < IDLE_PCT) begin
      out_ready <= 1'b0;
      if ($urandom_range(99) < 3) stall_left <= $urandom_range(1, 80);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    typed_want_t tw;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ATTACK: model_cfg.atk = cfg_data;
          REG_DECAY: model_cfg.dcy = cfg_data;
          REG_SUSTAIN: model_cfg.sus = cfg_data;
          REG_RELEASE: model_cfg.rel = cfg_data;
          REG_LEVEL: model_cfg.level = {16'd0, cfg_data[15:0]};
          REG_FREQ: model_cfg.freq = cfg_data;
          REG_OFFSET: model_cfg.offset = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = energy_update(in_data);
        if (typed_q.size() != 0) begin
          tw = typed_q.pop_front();
          if (tw.fixed) want = tw.want;
        end
        energy_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        region_hits[out_data.region]++;
        if (out_data.energy_out == 32'sh7FFF_FFFF || out_data.energy_out == 32'sh8000_0000)
          saturated++;
        if (energy_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: energy %h region %0d",
                     out_data.energy_out, out_data.region);
        end else begin
          want = energy_q.pop_front();
          if (out_data.energy_out !== want.energy_out || out_data.region !== want.region) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: energy %h region %0d, expected energy %h region %0d",
                       results_seen, out_data.energy_out, out_data.region,
                       want.energy_out, want.region);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, energy_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    env_cfg_t cur;
    int cur_sel;
    in_word_t w;
    model_cfg = make_cfg(32'd1, 32'd1, 32'd0, 32'd1, 32'd16384, 32'd0, 32'd0);
    for (int u = 0; u <= QUARTER; u++) quarter_sine[u] = taylor_sine(u);

    // zero phase gives a zero sine, so results under reset values are all zero
    dir_cfg[0] = model_cfg;
    dir_cfg[1] = make_cfg(32'd4, 32'd4, 32'd4, 32'd4, 32'd40000, 32'd0, 32'h4000_0000);
    dir_cfg[2] = make_cfg(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    dir_cfg[3] = make_cfg(32'd0, 32'd0, 32'd5, 32'd3, 32'd12345, 32'h0100_0000,
                          32'h8000_0000);
    dir_cfg[4] = make_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'd32768, 32'h9E37_79B9, 32'd0);

    add_row(0, 32'h0, 32'h7FFF_FFFF, 1, 32'h0, REGION_ATTACK);
    add_row(0, 32'h1, 32'h8000_0000, 1, 32'h0, REGION_DECAY);
    add_row(0, 32'h3, 32'h7FFF_FFFF, 1, 32'h0, REGION_RELEASE);
    add_row(0, 32'h0, 32'hFFFF_FFFF, 1, 32'h0, REGION_RELEASE);
    add_row(0, 32'hFFFF_FFFF, 32'h1, 1, 32'h0, REGION_RELEASE);
    // level above one, quarter-turn offset: sine at its peak
    add_row(1, 32'h02, 32'h7FFF_FFFF, 0, 32'h0, REGION_ATTACK);
    add_row(1, 32'h06, 32'h7FFF_FFFF, 0, 32'h0, REGION_ATTACK);
    add_row(1, 32'h0B, 32'h8000_0000, 0, 32'h0, REGION_ATTACK);
    add_row(1, 32'h13, 32'h7FFF_FFFF, 0, 32'h0, REGION_ATTACK);
    add_row(1, 32'h1B, 32'h7FFF_FFFF, 0, 32'h0, REGION_ATTACK);
    add_row(1, 32'h27, 32'h8000_0000, 0, 32'h0, REGION_ATTACK);
    add_row(1, 32'h36, 32'h1234_5678, 0, 32'h0, REGION_ATTACK);
    // release past its end: gain clamps at zero
    add_row(1, 32'h46, 32'h8000_0000, 1, 32'h0, REGION_RELEASE);
    // all ramps empty, zero release length gives zero gain
    add_row(2, 32'h0, 32'h7FFF_FFFF, 1, 32'h0, REGION_RELEASE);
    add_row(2, 32'h0, 32'h8000_0000, 1, 32'h0, REGION_RELEASE);
    add_row(2, 32'hFFFF_FFFF, 32'h5555_5555, 1, 32'h0, REGION_RELEASE);
    add_row(3, 32'h02, 32'h4000_0000, 0, 32'h0, REGION_ATTACK);
    add_row(3, 32'h06, 32'hC000_0000, 0, 32'h0, REGION_ATTACK);
    add_row(3, 32'h0B, 32'h7FFF_FFFF, 0, 32'h0, REGION_ATTACK);
    add_row(3, 32'h0D, 32'h8000_0000, 0, 32'h0, REGION_ATTACK);
    add_row(3, 32'h14, 32'h0001_0000, 0, 32'h0, REGION_ATTACK);
    // region bounds past 32 bits
    add_row(4, 32'h0, 32'h7FFF_FFFF, 0, 32'h0, REGION_ATTACK);
    add_row(4, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 32'h0, REGION_ATTACK);
    add_row(4, 32'hFFFF_FFFF, 32'h1, 0, 32'h0, REGION_ATTACK);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_sel = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].sel != cur_sel) begin
        settle();
        cur_sel = dir_rows[i].sel;
        load_settings(dir_cfg[cur_sel]);
      end
      send_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].want);
    end

    for (int p = 0; p < SETTING_COUNT; p++) begin
      settle();
      cur = random_settings();
      load_settings(cur);
      calm <= (p == 6 || p == 7);
      hold_pct = (p == 6 || p == 7) ? 0 : IDLE_PCT;
      for (int i = 0; i < WORDS_PER_SETTING; i++) begin
        w.current_time = next_time(cur);
        w.energy_in = next_energy();
        send_word(w, 1'b0, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d words under %0d register settings; %0d saturated results",
             sent_cnt, settings_loaded + 1, saturated);
    $display("regions hit: attack %0d, decay %0d, sustain %0d, release %0d",
             region_hits[0], region_hits[1], region_hits[2], region_hits[3]);
    if (mismatches == 0 && energy_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, energy_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
